// ===== hw/rtl/dfa_multistart_pattern_scanner_core_assert.svh =====
// Assertion macros used by the scanner core RTL.
`ifndef DFA_MULTISTART_PATTERN_SCANNER_CORE_ASSERT_SVH
`define DFA_MULTISTART_PATTERN_SCANNER_CORE_ASSERT_SVH

// Condition holds at every edge outside reset.
`define DFAMS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define DFAMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define DFAMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/dfams_pkg.sv =====
package dfams_pkg;

  localparam int NUM_STATES = 64;
  localparam int ST_W       = 6;
  localparam int SYM_W      = 8;
  localparam int TAB_AW     = ST_W + SYM_W;
  localparam int TAB_DEPTH  = NUM_STATES * 256;
  localparam int MAX_ACTIVE = 16;
  localparam int SLOT_AW    = 4;
  localparam int CNT_W      = 5;
  localparam int POS_W      = 16;

  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_ACCEPT = 3'd1;
  localparam logic [2:0] CMD_BEGIN  = 3'd2;
  localparam logic [2:0] CMD_SCAN   = 3'd3;
  localparam logic [2:0] CMD_END    = 3'd4;

  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // transition entry: valid flag above target state
  typedef struct packed {
    logic            valid;
    logic [ST_W-1:0] target;
  } tab_entry_t;

  typedef struct packed {
    logic [ST_W-1:0]  state;
    logic [POS_W-1:0] start;
  } slot_entry_t;

endpackage

// ===== hw/rtl/dfams_ram.sv =====
module dfams_ram #(
  parameter int AW = 4,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [(1 << AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/dfa_multistart_pattern_scanner_core.sv =====
// Multi-start DFA substring scanner. Load the DFA with transfers of cmd 0
// (transition) and cmd 1 (accepting flag), open a string with cmd 2, send one
// transfer of cmd 3 per character and close with cmd 4 for a summary. Every
// character advances each live recognizer in start order, drops those with no
// transition, reports matches, and then starts a new recognizer from state 0
// if state 0 has a transition and a slot is free. After reset the transition
// memory is cleared one entry a cycle, with in_tready low. A scan accepts the
// character, then per live recognizer reads its slot, reads the table and
// updates it through the two single-port-read memories, then reads the
// start-state entry, evaluates and finishes; the result side can stall it. Load,
// accepting and begin transfers are handled in idle; end uses a summary state.
`include "dfa_multistart_pattern_scanner_core_assert.svh"

module dfa_multistart_pattern_scanner_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [5:0] state_index, [13:6] symbol, [19:14] next_state, [20] entry_valid
  input  logic [23:0] in_tdata,
  // [2:0] cmd
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] match_start, [31:16] match_length, [32] any_match, [33] overflow
  output logic [39:0] out_tdata,
  // [0] kind
  output logic        out_tuser,
  output logic        out_tlast
);

  localparam int PW = dfams_pkg::POS_W;
  localparam int SW = dfams_pkg::ST_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_SRD  = 4'd2;
  localparam logic [3:0] S_STB  = 4'd3;
  localparam logic [3:0] S_SEV  = 4'd4;
  localparam logic [3:0] S_Z0R  = 4'd5;
  localparam logic [3:0] S_Z0E  = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_SUM  = 4'd8;

  logic [3:0]                         st_r;
  logic [dfams_pkg::TAB_AW:0]         clr_r;
  logic [dfams_pkg::SYM_W-1:0]        sym_r;
  logic [dfams_pkg::CNT_W-1:0]        rd_r, wr_r, cnt_r;
  logic [PW-1:0]                      pos_r;
  logic                               found_r, ovf_r;
  logic [dfams_pkg::NUM_STATES-1:0]   acc_r;
  logic                               pend_v_r;
  logic [PW-1:0]                      pend_start_r, pend_len_r;
  logic                               out_valid_r, out_kind_r, out_last_r;
  logic [PW-1:0]                      out_start_r, out_len_r;
  logic                               out_any_r, out_ovf_r;

  // input fields
  logic [2:0]                  in_cmd;
  logic [SW-1:0]               in_st, in_ns;
  logic [dfams_pkg::SYM_W-1:0] in_sym;
  logic                        in_ev;
  assign in_cmd = in_tuser;
  assign in_st  = in_tdata[5:0];
  assign in_sym = in_tdata[13:6];
  assign in_ns  = in_tdata[19:14];
  assign in_ev  = in_tdata[20];

  logic in_acc;
  assign in_tready = (st_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // transition memory
  logic                         tab_we;
  logic [dfams_pkg::TAB_AW-1:0] tab_wa, tab_ra;
  dfams_pkg::tab_entry_t        tab_wd, tab_q;
  logic                         tab_re;
  // recognizer slot memory
  logic                          slot_we, slot_re;
  logic [dfams_pkg::SLOT_AW-1:0] slot_wa, slot_ra;
  dfams_pkg::slot_entry_t        slot_wd, slot_q;

  always_comb begin
    tab_we = 1'b0;
    tab_wa = {in_st, in_sym};
    tab_wd = '{valid: in_ev, target: in_ns};
    if (st_r == S_CLR) begin
      tab_we = 1'b1;
      tab_wa = clr_r[dfams_pkg::TAB_AW-1:0];
      tab_wd = '0;
    end else if (in_acc && in_cmd == dfams_pkg::CMD_LOAD) begin
      tab_we = 1'b1;
    end
  end

  assign tab_re = (st_r == S_STB) || (st_r == S_Z0R);
  assign tab_ra = (st_r == S_STB) ? {slot_q.state, sym_r} : {{SW{1'b0}}, sym_r};

  // evaluate step: match detect and start
  logic          ev_match;
  logic [PW-1:0] ev_start;
  always_comb begin
    ev_match = 1'b0;
    ev_start = pos_r;
    if (st_r == S_SEV) begin
      ev_match = tab_q.valid && acc_r[tab_q.target];
      ev_start = slot_q.start;
    end else if (st_r == S_Z0E) begin
      ev_match = tab_q.valid ? acc_r[tab_q.target] : acc_r[0];
    end
  end

  logic out_free, ev_go;
  assign out_free = !out_valid_r || out_tready;
  assign ev_go    = !ev_match || !pend_v_r || out_free;

  // a new result enters the output register
  logic out_load;
  assign out_load = ((st_r == S_SEV || st_r == S_Z0E) && ev_go && ev_match && pend_v_r) ||
                    (st_r == S_FIN && pend_v_r && out_free) ||
                    (st_r == S_SUM && out_free);

  always_comb begin
    slot_we = 1'b0;
    slot_wa = wr_r[dfams_pkg::SLOT_AW-1:0];
    slot_wd = '{state: tab_q.target, start: slot_q.start};
    if (st_r == S_SEV && tab_q.valid) begin
      slot_we = 1'b1;
    end else if (st_r == S_Z0E && tab_q.valid &&
                 cnt_r < dfams_pkg::CNT_W'(dfams_pkg::MAX_ACTIVE)) begin
      slot_we = 1'b1;
      slot_wa = cnt_r[dfams_pkg::SLOT_AW-1:0];
      slot_wd = '{state: tab_q.target, start: pos_r};
    end
  end

  assign slot_re = (st_r == S_SRD) && (rd_r != cnt_r);
  assign slot_ra = rd_r[dfams_pkg::SLOT_AW-1:0];

  dfams_ram #(.AW(dfams_pkg::TAB_AW), .DW($bits(dfams_pkg::tab_entry_t))) u_tab (
    .clk(clk), .we(tab_we), .waddr(tab_wa), .wdata(tab_wd),
    .re(tab_re), .raddr(tab_ra), .rdata(tab_q)
  );

  dfams_ram #(.AW(dfams_pkg::SLOT_AW), .DW($bits(dfams_pkg::slot_entry_t))) u_slot (
    .clk(clk), .we(slot_we), .waddr(slot_wa), .wdata(slot_wd),
    .re(slot_re), .raddr(slot_ra), .rdata(slot_q)
  );

  logic [PW-1:0] pos_inc;
  assign pos_inc = pos_r + PW'(1);

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sym_r <= in_sym;
    end
  end

  // output valid: set on a load, drop once the transfer is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      clr_r       <= '0;
      rd_r        <= '0;
      wr_r        <= '0;
      cnt_r       <= '0;
      pos_r       <= '0;
      found_r     <= 1'b0;
      ovf_r       <= 1'b0;
      acc_r       <= '0;
      pend_v_r    <= 1'b0;
    end else begin
      unique case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (dfams_pkg::TAB_AW+1)'(dfams_pkg::TAB_DEPTH - 1)) begin
            st_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_cmd)
              dfams_pkg::CMD_ACCEPT: acc_r[in_st] <= in_ev;
              dfams_pkg::CMD_BEGIN: begin
                cnt_r   <= '0;
                pos_r   <= '0;
                found_r <= 1'b0;
                ovf_r   <= 1'b0;
              end
              dfams_pkg::CMD_SCAN: begin
                rd_r <= '0;
                wr_r <= '0;
                st_r <= S_SRD;
              end
              dfams_pkg::CMD_END: st_r <= S_SUM;
              default: ;
            endcase
          end
        end
        S_SRD: begin
          if (rd_r == cnt_r) begin
            cnt_r <= wr_r;
            st_r  <= S_Z0R;
          end else begin
            rd_r <= rd_r + 1'b1;
            st_r <= S_STB;
          end
        end
        S_STB: st_r <= S_SEV;
        S_Z0R: st_r <= S_Z0E;
        S_SEV, S_Z0E: begin
          if (ev_go) begin
            if (ev_match) begin
              // push the older pending match out, hold the new one
              if (pend_v_r) begin
                out_kind_r  <= dfams_pkg::KIND_MATCH;
                out_start_r <= pend_start_r;
                out_len_r   <= pend_len_r;
                out_any_r   <= 1'b0;
                out_ovf_r   <= 1'b0;
                out_last_r  <= 1'b0;
              end
              pend_v_r     <= 1'b1;
              pend_start_r <= ev_start;
              pend_len_r   <= pos_inc - ev_start;
              found_r      <= 1'b1;
            end
            if (st_r == S_SEV) begin
              if (tab_q.valid) begin
                wr_r <= wr_r + 1'b1;
              end
              st_r <= S_SRD;
            end else begin
              if (tab_q.valid) begin
                if (cnt_r < dfams_pkg::CNT_W'(dfams_pkg::MAX_ACTIVE)) begin
                  cnt_r <= cnt_r + 1'b1;
                end else begin
                  ovf_r <= 1'b1;
                end
              end
              st_r <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              out_kind_r  <= dfams_pkg::KIND_MATCH;
              out_start_r <= pend_start_r;
              out_len_r   <= pend_len_r;
              out_any_r   <= 1'b0;
              out_ovf_r   <= 1'b0;
              out_last_r  <= 1'b1;
            end
            pend_v_r <= 1'b0;
            pos_r    <= pos_inc;
            if (pos_inc == '0) begin
              ovf_r <= 1'b1;
            end
            st_r <= S_IDLE;
          end
        end
        S_SUM: begin
          if (out_free) begin
            out_kind_r  <= dfams_pkg::KIND_SUMMARY;
            out_start_r <= '0;
            out_len_r   <= '0;
            out_any_r   <= found_r;
            out_ovf_r   <= ovf_r;
            out_last_r  <= 1'b1;
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'd0, out_ovf_r, out_any_r, out_len_r, out_start_r};

  `DFAMS_ASSERT_ALWAYS(a_cnt_max, cnt_r <= dfams_pkg::CNT_W'(dfams_pkg::MAX_ACTIVE), "slot count above capacity")
  `DFAMS_ASSERT_IMP(a_wr_le_rd, st_r == S_SRD || st_r == S_SEV, wr_r <= rd_r, "compaction write ahead of read")
  `DFAMS_ASSERT_IMP(a_idle_no_pend, st_r == S_IDLE, !pend_v_r, "match left pending after scan")
  `DFAMS_ASSERT_NXT(a_scan_starts, in_acc && in_cmd == dfams_pkg::CMD_SCAN, st_r == S_SRD, "scan did not start")

endmodule

// ===== sim/testbench.sv =====
module testbench;

  typedef struct packed {
    logic [2:0] cmd;
    logic [5:0] state_index;
    logic [7:0] symbol;
    logic [5:0] next_state;
    logic       entry_valid;
  } scan_cmd_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] match_start;
    logic [15:0] match_length;
    logic        any_match;
    logic        overflow;
    logic        last;
  } scan_report_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  dfa_multistart_pattern_scanner_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // predictor state: table entry is {valid, target}
  logic [6:0]  dfa_next [0:dfams_pkg::TAB_DEPTH-1];
  logic        dfa_accept [0:dfams_pkg::NUM_STATES-1];
  logic [5:0]  live_state [0:dfams_pkg::MAX_ACTIVE-1];
  logic [15:0] live_start [0:dfams_pkg::MAX_ACTIVE-1];
  int          live_count;
  logic [15:0] char_pos;
  logic        seen_match;
  logic        ovf_sticky;

  scan_cmd_t    pending_cmds[$];
  scan_report_t expected_reports[$];
  int           fail_count;
  int           send_idle_pct;
  int           recv_idle_pct;
  bit           recv_hold;
  bit           send_pause;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic scan_report_t match_report(logic [15:0] st);
    scan_report_t r;
    r = '0;
    r.kind = dfams_pkg::KIND_MATCH;
    r.match_start = st;
    r.match_length = char_pos - st + 16'd1;
    seen_match = 1'b1;
    return r;
  endfunction

  // Work out the reports that one accepted command causes.
  task automatic predict_scanner(scan_cmd_t c);
    scan_report_t reps[$];
    scan_report_t r;
    logic [6:0] e;
    int w;
    if (c.cmd == dfams_pkg::CMD_LOAD) begin
      if (!c.entry_valid) dfa_next[{c.state_index, c.symbol}] = '0;
      else dfa_next[{c.state_index, c.symbol}] = {1'b1, c.next_state};
    end else if (c.cmd == dfams_pkg::CMD_ACCEPT) begin
      dfa_accept[c.state_index] = c.entry_valid;
    end else if (c.cmd == dfams_pkg::CMD_BEGIN) begin
      live_count = 0; char_pos = '0; seen_match = 0; ovf_sticky = 0;
    end else if (c.cmd == dfams_pkg::CMD_END) begin
      r = '0;
      r.kind = dfams_pkg::KIND_SUMMARY; r.any_match = seen_match; r.overflow = ovf_sticky;
      reps = {reps, r};
    end else if (c.cmd == dfams_pkg::CMD_SCAN) begin
      w = 0;
      for (int i = 0; i < live_count; i++) begin
        e = dfa_next[{live_state[i], c.symbol}];
        if (e[6]) begin
          live_state[w] = e[5:0];
          live_start[w] = live_start[i];
          if (dfa_accept[e[5:0]]) reps = {reps, match_report(live_start[w])};
          w++;
        end
      end
      live_count = w;
      e = dfa_next[{6'd0, c.symbol}];
      if (e[6]) begin
        if (live_count < dfams_pkg::MAX_ACTIVE) begin
          live_state[live_count] = e[5:0];
          live_start[live_count] = char_pos;
          live_count++;
        end else ovf_sticky = 1'b1;
        if (dfa_accept[e[5:0]]) reps = {reps, match_report(char_pos)};
      end else if (dfa_accept[0]) reps = {reps, match_report(char_pos)};
      char_pos = char_pos + 16'd1;
      if (char_pos == 16'd0) ovf_sticky = 1'b1;
    end
    if (reps.size() > 0) reps[reps.size()-1].last = 1'b1;
    foreach (reps[i]) expected_reports = {expected_reports, reps[i]};
  endtask

  // Driver: offer the head of the queue, advance on each transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_scanner(pending_cmds.pop_front());
      end
      if (in_tvalid && !in_tready) begin
        // hold the offer
      end else if (pending_cmds.size() > 0 && !send_pause &&
                   $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tuser  <= pending_cmds[0].cmd;
        in_tdata  <= {3'd0, pending_cmds[0].entry_valid, pending_cmds[0].next_state,
                      pending_cmds[0].symbol, pending_cmds[0].state_index};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    scan_report_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[15:0], out_tdata[31:16], out_tdata[32],
               out_tdata[33], out_tlast};
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
            fail_count++;
          end
        end
      end
      out_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_cmd(logic [2:0] cmd, logic [5:0] st, logic [7:0] sym,
                         logic [5:0] nxt, logic v);
    scan_cmd_t c;
    c.cmd = cmd; c.state_index = st; c.symbol = sym; c.next_state = nxt;
    c.entry_valid = v;
    pending_cmds = {pending_cmds, c};
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_tvalid || expected_reports.size() > 0)
      @(posedge clk);
  endtask

  // A random string over a small alphabet so that recognizers chain.
  task automatic add_string(int len);
    add_cmd(dfams_pkg::CMD_BEGIN, 6'($urandom), 8'($urandom), 6'($urandom), 1'($urandom));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0)
        add_cmd(dfams_pkg::CMD_SCAN, 6'($urandom), 8'($urandom), 6'($urandom),
                1'($urandom));
      else
        add_cmd(dfams_pkg::CMD_SCAN, 6'($urandom), 8'(8'h61 + $urandom_range(2)),
                6'($urandom), 1'($urandom));
    end
    add_cmd(dfams_pkg::CMD_END, 6'($urandom), 8'($urandom), 6'($urandom), 1'($urandom));
  endtask

  initial begin
    for (int i = 0; i < dfams_pkg::TAB_DEPTH; i++) dfa_next[i] = '0;
    for (int i = 0; i < dfams_pkg::NUM_STATES; i++) dfa_accept[i] = 1'b0;
    for (int i = 0; i < dfams_pkg::MAX_ACTIVE; i++) begin
      live_state[i] = '0; live_start[i] = '0;
    end
    live_count = 0; char_pos = '0; seen_match = 0; ovf_sticky = 0;
    fail_count = 0; send_idle_pct = 31; recv_idle_pct = 52;
    recv_hold = 0; send_pause = 0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0; out_tready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: pattern "ab", state 0 on 'a', self-loop on 'a', extremes.
    add_cmd(dfams_pkg::CMD_LOAD, 6'd0, 8'h61, 6'd1, 1'b1);
    add_cmd(dfams_pkg::CMD_LOAD, 6'd1, 8'h62, 6'd63, 1'b1);
    add_cmd(dfams_pkg::CMD_LOAD, 6'd1, 8'h61, 6'd1, 1'b1);
    add_cmd(dfams_pkg::CMD_LOAD, 6'd63, 8'hff, 6'd2, 1'b1);
    add_cmd(dfams_pkg::CMD_LOAD, 6'd63, 8'hff, 6'd2, 1'b0);
    add_cmd(dfams_pkg::CMD_ACCEPT, 6'd63, 8'hff, 6'd63, 1'b1);
    add_cmd(dfams_pkg::CMD_ACCEPT, 6'd2, 8'h00, 6'd0, 1'b0);
    add_cmd(3'd5, 6'd63, 8'hff, 6'd63, 1'b1);
    add_cmd(3'd7, 6'd0, 8'h00, 6'd0, 1'b0);
    add_cmd(dfams_pkg::CMD_SCAN, 6'd0, 8'h62, 6'd0, 1'b0);  // scan before any begin
    add_cmd(dfams_pkg::CMD_BEGIN, 6'd0, 8'h00, 6'd0, 1'b0);
    add_cmd(dfams_pkg::CMD_SCAN, 6'd0, 8'h61, 6'd0, 1'b0);
    add_cmd(dfams_pkg::CMD_SCAN, 6'd0, 8'h62, 6'd0, 1'b0);
    add_cmd(dfams_pkg::CMD_SCAN, 6'd0, 8'h00, 6'd0, 1'b0);
    add_cmd(dfams_pkg::CMD_END, 6'd0, 8'h00, 6'd0, 1'b0);
    // accepting start state without a transition
    add_cmd(dfams_pkg::CMD_ACCEPT, 6'd0, 8'h00, 6'd0, 1'b1);
    add_cmd(dfams_pkg::CMD_BEGIN, 6'd0, 8'h00, 6'd0, 1'b0);
    add_cmd(dfams_pkg::CMD_SCAN, 6'd0, 8'h7a, 6'd0, 1'b0);
    add_cmd(dfams_pkg::CMD_END, 6'd0, 8'h00, 6'd0, 1'b0);
    add_cmd(dfams_pkg::CMD_ACCEPT, 6'd0, 8'h00, 6'd0, 1'b0);
    // slots full: eighteen 'a' keeps every recognizer alive
    add_string(0);
    pending_cmds.pop_back();
    for (int i = 0; i < 18; i++) add_cmd(dfams_pkg::CMD_SCAN, 6'd0, 8'h61, 6'd0, 1'b0);
    add_cmd(dfams_pkg::CMD_END, 6'd0, 8'h00, 6'd0, 1'b0);
    wait_drained();

    // Random DFA over a small state set, then strings; loads stay random noise.
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin send_idle_pct = 52; recv_idle_pct = 31; end
      if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int i = 0; i < 12; i++)
        add_cmd(dfams_pkg::CMD_LOAD, 6'($urandom_range(5)), 8'(8'h61 + $urandom_range(2)),
                6'($urandom_range(5)), $urandom_range(3) != 0);
      for (int i = 0; i < 3; i++)
        add_cmd(dfams_pkg::CMD_ACCEPT, 6'($urandom_range(1, 5)), 8'($urandom),
                6'($urandom), 1'($urandom));
      add_cmd(dfams_pkg::CMD_LOAD, 6'($urandom), 8'($urandom), 6'($urandom), 1'($urandom));
      add_cmd(3'($urandom_range(5, 7)), 6'($urandom), 8'($urandom), 6'($urandom),
              1'($urandom));
      add_string(8 + $urandom_range(6));
      add_string(8 + $urandom_range(6));
      if (phase == 0) begin
        // pause the sender mid-stream until every expected result is in
        repeat (60) @(posedge clk);
        send_pause = 1'b1;
        while (in_tvalid || expected_reports.size() > 0) @(posedge clk);
        send_pause = 1'b0;
      end
      if (phase == 1) begin
        // long receiver hold-off while the sender keeps offering
        recv_hold = 1'b1;
        repeat (400) @(posedge clk);
        recv_hold = 1'b0;
      end
      wait_drained();
    end
    repeat (100) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/dfams_pkg.sv
hw/rtl/dfams_ram.sv
hw/rtl/dfa_multistart_pattern_scanner_core.sv
sim/testbench.sv
